>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SUDC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent, reset included.
`define SUDC_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sudc_pkg.sv
// ----------------------------------------------------------------------------
// sudc_pkg
// Shared constants and types of the SMS user data codec.
// ----------------------------------------------------------------------------
`default_nettype none

package sudc_pkg;

  // Depth of the result queue between front and back, in items
  localparam int QUEUE_DEPTH = 4;

  // Mode register codes
  localparam logic [1:0] MODE_PACK   = 2'd0;
  localparam logic [1:0] MODE_UNPACK = 2'd1;
  localparam logic [1:0] MODE_ENC    = 2'd2;
  localparam logic [1:0] MODE_DEC    = 2'd3;

  localparam logic [6:0] CHAR_MASK = 7'h7F;

  // One queued item: one or two result bytes, plus the end-of-message mark
  typedef struct packed {
    logic       two;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic       last;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/sudc_front.sv
// ----------------------------------------------------------------------------
// sudc_front
// Accepts input words, holds the stream state and mode, and turns each word
// into a queue entry of zero, one or two result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sudc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_mode,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_in,
  input  wire logic               last_in,
  output logic                    push_valid,
  output sudc_pkg::entry_t        push_entry,
  input  wire logic               push_ready
);

  logic [1:0]  mode;
  logic [6:0]  carry_bits;
  logic [2:0]  bit_offset;
  logic        pair_phase;
  logic        high_was_zero;

  logic [6:0]  carry_bits_next;
  logic [2:0]  bit_offset_next;
  logic        pair_phase_next;
  logic        high_was_zero_next;

  logic        accept;
  logic [14:0] shift_in;
  logic [14:0] acc;
  logic [1:0]  res_cnt;
  logic [7:0]  res0;
  logic [7:0]  res1;

  assign cfg_ready = 1'b1;
  assign in_stall  = !push_ready;
  assign accept    = in_valid && push_ready;

  // Merge the new byte above the held bits
  assign shift_in = (mode == sudc_pkg::MODE_PACK) ?
                    {8'd0, data_in[6:0] & sudc_pkg::CHAR_MASK} : {7'd0, data_in};
  assign acc      = {8'd0, carry_bits} | (shift_in << bit_offset);

  // Classify the word and form its results
  always_comb begin
    res_cnt            = 2'd0;
    res0               = 8'd0;
    res1               = 8'd0;
    carry_bits_next    = carry_bits;
    bit_offset_next    = bit_offset;
    pair_phase_next    = pair_phase;
    high_was_zero_next = high_was_zero;
    case (mode)
      sudc_pkg::MODE_PACK: begin
        if (bit_offset != 3'd0) begin
          res0            = acc[7:0];
          res_cnt         = 2'd1;
          carry_bits_next = acc[14:8];
          bit_offset_next = bit_offset - 3'd1;
        end else begin
          carry_bits_next = acc[6:0];
          bit_offset_next = 3'd7;
        end
        // flush leftover bits on the final character
        if (last_in && bit_offset_next != 3'd0) begin
          if (bit_offset != 3'd0) begin
            res1 = {1'b0, carry_bits_next};
          end else begin
            res0 = {1'b0, carry_bits_next};
          end
          res_cnt = res_cnt + 2'd1;
        end
      end
      sudc_pkg::MODE_UNPACK: begin
        res0    = {1'b0, acc[6:0]};
        res_cnt = 2'd1;
        if (bit_offset >= 3'd6) begin
          res1            = {1'b0, acc[13:7]};
          res_cnt         = 2'd2;
          carry_bits_next = 7'd0;
          bit_offset_next = 3'd0;
        end else begin
          carry_bits_next = acc[13:7];
          bit_offset_next = bit_offset + 3'd1;
        end
      end
      sudc_pkg::MODE_ENC: begin
        res0    = 8'd0;
        res1    = data_in;
        res_cnt = 2'd2;
      end
      default: begin
        if (!pair_phase) begin
          high_was_zero_next = (data_in == 8'd0);
          pair_phase_next    = 1'b1;
        end else begin
          if (high_was_zero) begin
            res0    = data_in;
            res_cnt = 2'd1;
          end
          pair_phase_next    = 1'b0;
          high_was_zero_next = 1'b0;
        end
      end
    endcase
  end

  // Hand the results to the queue
  assign push_valid             = accept && (res_cnt != 2'd0);
  assign push_entry.two         = res_cnt[1];
  assign push_entry.first_data  = res0;
  assign push_entry.second_data = res1;
  assign push_entry.last        = last_in;

  // Hold mode and stream state; clear on mode write and message end
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= sudc_pkg::MODE_PACK;
      carry_bits    <= 7'd0;
      bit_offset    <= 3'd0;
      pair_phase    <= 1'b0;
      high_was_zero <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode          <= cfg_mode;
      carry_bits    <= 7'd0;
      bit_offset    <= 3'd0;
      pair_phase    <= 1'b0;
      high_was_zero <= 1'b0;
    end else if (accept) begin
      if (last_in) begin
        carry_bits    <= 7'd0;
        bit_offset    <= 3'd0;
        pair_phase    <= 1'b0;
        high_was_zero <= 1'b0;
      end else begin
        carry_bits    <= carry_bits_next;
        bit_offset    <= bit_offset_next;
        pair_phase    <= pair_phase_next;
        high_was_zero <= high_was_zero_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sudc_back.sv
// ----------------------------------------------------------------------------
// sudc_back
// Queues result entries and sends them out one byte per word, first byte
// then second byte of a two-byte entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sudc_back #(
  parameter int DEPTH = sudc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  wire sudc_pkg::entry_t  push_entry,
  output logic                   push_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             data_out,
  output logic                   last_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sudc_pkg::entry_t  store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              half;

  sudc_pkg::entry_t  head;
  logic              tail_byte;
  logic              pop;
  logic              push;

  assign head       = store[rd_ptr];
  assign push_ready = (count != CNT_W'(DEPTH));
  assign push       = push_valid && push_ready;
  assign out_valid  = (count != '0);
  assign tail_byte  = half || !head.two;
  assign pop        = out_valid && !out_stall && tail_byte;
  assign data_out   = half ? head.second_data : head.first_data;
  assign last_out   = head.last && tail_byte;

  // Write the entry store
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers, count and byte select
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      half   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
      if (out_valid && !out_stall) begin
        half <= !pop;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sms_user_data_codec_top.sv
// ----------------------------------------------------------------------------
// sms_user_data_codec_top
// SMS user data codec: septet pack/unpack and UCS2 encode/filter-decode.
// ----------------------------------------------------------------------------
// A byte word is accepted in every cycle while the result queue has room, and
// its results are queued behind older entries. The output moves one byte per
// cycle while not stalled, so a word that gives one result sustains one word
// per cycle, and a word that gives two (UCS2 encode, every seventh unpacked
// octet, a pack flush beside a full octet) holds the output for both bytes;
// the queue of QUEUE_DEPTH entries absorbs such bursts before the input stalls.
// The mode register has its own, always ready port; writes clear stream state.
`default_nettype none

`include "assert_macros.svh"

module sms_user_data_codec_top #(
  parameter int QUEUE_DEPTH = sudc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] mode,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_in,
  input  wire logic       last_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_out,
  output logic            last_out
);

  logic              push_valid;
  logic              push_ready;
  logic              push_fire;
  sudc_pkg::entry_t  push_entry;

  assign push_fire = push_valid && push_ready;

  // Classify words and update stream state
  sudc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_mode   (mode),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_in    (data_in),
    .last_in    (last_in),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Queue and serialize results
  sudc_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .last_out   (last_out)
  );

  // A full queue must have something to send
  `SUDC_ASSERT_ALWAYS(a_stall_has_output, clk, rst, !in_stall || out_valid, "stall while empty")
  // Reset empties the queue
  `SUDC_ASSERT_NEXT(a_reset_empties, clk, rst, !out_valid, "output valid after reset")
  // After an accepted word with results, the output is valid in the next cycle
  `SUDC_ASSERT_NEXT(a_push_visible, clk, !rst && push_fire, out_valid, "pushed word not visible")

endmodule

`default_nettype wire

>>> tb/sudc_checker.sv
// ----------------------------------------------------------------------------
// sudc_checker
// Watches the mode, input and output channels of the SMS user data codec. It
// keeps its own copy of the mode and the stream state, predicts the result
// words of every accepted input word, and compares each accepted result word
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sudc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] mode,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_in,
  input  logic       last_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] data_out,
  input  logic       last_out,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  out_word_t  expected_words[$];
  int         errors = 0;

  // Shadow copy of the mode register and the stream state
  logic [1:0] cur_mode;
  logic [6:0] carry;
  logic [2:0] offset;
  logic       pair_phase;
  logic       high_zero;

  assign fail_count = errors;

  task automatic clear_stream();
    carry      = '0;
    offset     = '0;
    pair_phase = 1'b0;
    high_zero  = 1'b0;
  endtask

  // Work out the result words of one input word and queue them
  task automatic convert_byte(input logic [7:0] d, input logic l);
    logic [14:0] acc;
    logic [7:0]  res [2];
    int          n;
    n = 0;
    case (cur_mode)
      sudc_pkg::MODE_PACK: begin
        acc = 15'(carry) | (15'(d[6:0] & sudc_pkg::CHAR_MASK) << offset);
        if (offset != 3'd0) begin
          res[n] = acc[7:0];
          n = n + 1;
          carry = acc[14:8];
          offset = offset - 3'd1;
        end else begin
          carry = acc[6:0];
          offset = 3'd7;
        end
        // flush leftover bits as a zero-padded octet
        if (l && offset != 3'd0) begin
          res[n] = {1'b0, carry};
          n = n + 1;
        end
      end
      sudc_pkg::MODE_UNPACK: begin
        acc = 15'(carry) | (15'(d) << offset);
        res[n] = {1'b0, acc[6:0]};
        n = n + 1;
        if (offset >= 3'd6) begin
          res[n] = {1'b0, acc[13:7]};
          n = n + 1;
          carry = '0;
          offset = '0;
        end else begin
          carry = acc[13:7];
          offset = offset + 3'd1;
        end
      end
      sudc_pkg::MODE_ENC: begin
        res[0] = 8'h00;
        res[1] = d;
        n = 2;
      end
      sudc_pkg::MODE_DEC: begin
        if (!pair_phase) begin
          high_zero = (d == 8'h00);
          pair_phase = 1'b1;
        end else begin
          if (high_zero) begin
            res[n] = d;
            n = n + 1;
          end
          pair_phase = 1'b0;
          high_zero = 1'b0;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      expected_words.push_back('{data: res[i], last: l && (i == n - 1)});
    end
    if (l) clear_stream();
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      cur_mode = sudc_pkg::MODE_PACK;
      clear_stream();
      expected_words.delete();
    end else begin
      // Compare an accepted result word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word: data_out %02h last_out %0b",
                   $time, data_out, last_out);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (data_out !== want.data) begin
            $display("%0t: data_out mismatch: expected %02h, actual %02h",
                     $time, want.data, data_out);
            errors++;
          end
          if (last_out !== want.last) begin
            $display("%0t: last_out mismatch: expected %0b, actual %0b",
                     $time, want.last, last_out);
            errors++;
          end
        end
      end
      // A mode write also clears the stream state
      if (cfg_valid && cfg_ready) begin
        cur_mode = mode;
        clear_stream();
      end
      if (in_valid && !in_stall) convert_byte(data_in, last_in);
    end
    pending <= expected_words.size();
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the SMS user data codec through all four modes: a short directed
// part on the edge cases of each mode, then random messages in phases with
// different modes, sender bursts and receiver stall patterns, including a
// long output hold-off. The checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS  = 1550;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 80;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] mode;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_in;
  logic       last_in;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] data_out;
  logic       last_out;

  int fail_count;
  int pending;

  // Sender and receiver pacing, changed per phase
  int         idle_max    = 0;
  int         burst_left  = 0;
  int         stall_style = 0;
  logic [7:0] stall_pat   = 8'b1100_1010;
  logic       hold_req    = 1'b0;
  int         words_sent  = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  sms_user_data_codec_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .mode      (mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_in   (data_in),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .last_out  (last_out)
  );

  sudc_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .mode       (mode),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_in    (data_in),
    .last_in    (last_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data_out   (data_out),
    .last_out   (last_out),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver: long hold-off on request, otherwise the phase's stall pattern
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall = 1'b1;
      end else begin
        case (stall_style)
          1: out_stall = ($urandom_range(0, 2) == 0);
          2: begin
            stall_pat = {stall_pat[0], stall_pat[7:1]};
            out_stall = stall_pat[0];
          end
          3: out_stall = ($urandom_range(0, 9) < 7);
          default: out_stall = 1'b0;
        endcase
      end
    end
  end

  // Offer one word and hold it until accepted; insert a gap at a burst end
  task automatic push_byte(input logic [7:0] d, input logic l);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    data_in = d;
    last_in = l;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (idle_max > 0) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(1, idle_max);
        burst_left = $urandom_range(1, 16);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Pause the sender until every predicted word has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    mode = m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Byte for position pos of a message; high bytes in decode mode mostly zero
  function automatic logic [7:0] pick_byte(input logic [1:0] m, input int pos);
    if (m == sudc_pkg::MODE_DEC && pos % 2 == 0 && $urandom_range(0, 9) < 7) return 8'h00;
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Send one message; now and then drop its end mark so messages run together
  task automatic send_message(input logic [1:0] m);
    int   len;
    int   r;
    logic cut;
    r = $urandom_range(0, 9);
    if (r < 2) len = $urandom_range(1, 3);
    else if (r < 8) len = $urandom_range(1, 16);
    else len = $urandom_range(17, 40);
    if (m == sudc_pkg::MODE_UNPACK && $urandom_range(0, 3) == 0) len = 7 * $urandom_range(1, 4);
    if (m == sudc_pkg::MODE_DEC && len % 2 == 1 && $urandom_range(0, 4) != 0) len++;
    cut = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < len; i++) begin
      push_byte(pick_byte(m, i), (i == len - 1) && !cut);
    end
  endtask

  initial begin
    int         base;
    int         target;
    logic [1:0] m;
    rst = 1'b1;
    cfg_valid = 1'b0;
    mode = sudc_pkg::MODE_PACK;
    in_valid = 1'b0;
    data_in = 8'h00;
    last_in = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Pack from the reset mode: extremes, ignored top bit, flush on the end
    idle_max = 3;
    stall_style = 1;
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h2A, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h41, 1'b1);

    // Unpack: second character after the seventh octet, partial septet dropped
    write_mode(sudc_pkg::MODE_UNPACK);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h12, 1'b1);

    write_mode(sudc_pkg::MODE_ENC);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    // Decode: kept pair, dropped pair ending a message, odd trailing byte
    write_mode(sudc_pkg::MODE_DEC);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h42, 1'b1);
    push_byte(8'h00, 1'b1);

    // Random phases, each with its own mode and pacing
    base = words_sent;
    for (int phase = 0; words_sent - base < RANDOM_WORDS; phase++) begin
      m = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
      write_mode(m);
      if (phase % 5 == 0) begin
        idle_max = 0;
        stall_style = 0;
      end else begin
        idle_max = $urandom_range(1, 8);
        stall_style = $urandom_range(1, 3);
        stall_pat = 8'($urandom);
        if (stall_pat == 8'hFF) stall_pat = 8'hF0;
      end
      // Hold the output off while the sender keeps pushing, to fill the block
      if (phase == 2) begin
        idle_max = 0;
        hold_req = 1'b1;
      end
      target = $urandom_range(50, 80);
      repeat (2) begin
        target = words_sent + target;
        while (words_sent < target) send_message(m);
        drain_results();
        target = target - words_sent + $urandom_range(50, 80);
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
